### sv/sap_pkg.sv
// Shared types and constants for the sigmoid angle profile unit.
package sap_pkg;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_START  = 3'd1,
    REG_TARGET = 3'd2,
    REG_DUR    = 3'd3,
    REG_STEEP  = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    MODE_SIGMOID = 1'b0,
    MODE_LINEAR  = 1'b1
  } mode_e;

  localparam logic [15:0] DUR_RST   = 16'd1;
  localparam logic [15:0] STEEP_RST = 16'd1000;

  // n saturation limit
  localparam int          N_SAT     = 65536;
  // y = n * 2^Q * 25000 / 34657359  (100000 / 138629436 reduced)
  localparam logic [14:0] Y_MUL     = 15'd25000;
  localparam int unsigned YDIV_DEN  = 34657359;
  localparam int          MAG_W     = 17;

  typedef struct packed {
    logic              neg;
    logic [15:0]       t;
    logic [MAG_W-1:0]  mag;
  } front_t;

endpackage

### sv/sap_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module sap_div #(
  parameter int NW = 48,
  parameter int DW = 26,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [NW-1:0] vld_q;
  logic [NW-1:0] num_q  [NW];
  logic [NW-1:0] quo_q  [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  logic [NW-1:0] cur_num  [NW];
  logic [NW-1:0] cur_quo  [NW];
  logic [DW-1:0] cur_rem  [NW];
  logic [DW-1:0] cur_den  [NW];
  logic [SW-1:0] cur_side [NW];
  logic [DW:0]   trial    [NW];
  logic [DW:0]   sub      [NW];
  logic [NW-1:0] ge;
  logic [NW-1:0] num_d    [NW];
  logic [NW-1:0] quo_d    [NW];
  logic [DW-1:0] rem_d    [NW];

  always_comb begin
    cur_num[0]  = num_i;
    cur_quo[0]  = '0;
    cur_rem[0]  = '0;
    cur_den[0]  = den_i;
    cur_side[0] = side_i;
    for (int s = 1; s < NW; s++) begin
      cur_num[s]  = num_q[s-1];
      cur_quo[s]  = quo_q[s-1];
      cur_rem[s]  = rem_q[s-1];
      cur_den[s]  = den_q[s-1];
      cur_side[s] = side_q[s-1];
    end
    for (int s = 0; s < NW; s++) begin
      trial[s] = {cur_rem[s], cur_num[s][NW-1]};
      sub[s]   = trial[s] - {1'b0, cur_den[s]};
      ge[s]    = trial[s] >= {1'b0, cur_den[s]};
      rem_d[s] = ge[s] ? sub[s][DW-1:0] : trial[s][DW-1:0];
      num_d[s] = cur_num[s] << 1;
      quo_d[s] = {cur_quo[s][NW-2:0], ge[s]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NW-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NW; s++) begin
        num_q[s]  <= num_d[s];
        quo_q[s]  <= quo_d[s];
        rem_q[s]  <= rem_d[s];
        den_q[s]  <= cur_den[s];
        side_q[s] <= cur_side[s];
      end
    end
  end

  assign vld_o  = vld_q[NW-1];
  assign quo_o  = quo_q[NW-1];
  assign side_o = side_q[NW-1];

endmodule

### sv/sap_front.sv
// Front stages: time capture, k*(T-2t), saturation and magnitude of n.
module sap_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic [15:0]         time_i,
  input  logic [15:0]         dur_i,
  input  logic [15:0]         steep_i,
  output logic                vld_o,
  output sap_pkg::front_t     data_o
);

  logic               v1_q, v2_q, v3_q, v4_q;
  logic [15:0]        t1_q, t2_q, t3_q;
  logic signed [17:0] d_d, d2_q;
  logic signed [34:0] n_d, n3_q;
  logic signed [34:0] ns;
  logic [16:0]        nmag;
  sap_pkg::front_t    f_d, f4_q;

  assign d_d = $signed({2'b00, dur_i}) - $signed({1'b0, t1_q, 1'b0});
  assign n_d = $signed({1'b0, steep_i}) * d2_q;

  always_comb begin
    if (n3_q > 35'(sap_pkg::N_SAT)) begin
      ns = 35'(sap_pkg::N_SAT);
    end else if (n3_q < -35'(sap_pkg::N_SAT)) begin
      ns = -35'(sap_pkg::N_SAT);
    end else begin
      ns = n3_q;
    end
    nmag     = ns[34] ? 17'(-ns) : ns[16:0];
    f_d.neg  = ns[34];
    f_d.t    = t3_q;
    f_d.mag  = nmag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q <= time_i;
      t2_q <= t1_q;
      d2_q <= d_d;
      t3_q <= t2_q;
      n3_q <= n_d;
      f4_q <= f_d;
    end
  end

  assign vld_o  = v4_q;
  assign data_o = f4_q;

endmodule

### sv/sigmoid_angle_profile_unit.sv
// Top level of the sigmoid angle profile unit: config registers, exponent and output stages.
// Accepts one time item per cycle while stall_o is low and returns one angle item per item in
// order, through four front stages, two reciprocal-multiply stages that scale the exponent,
// two exponent stages, the angle divider (16 + FRAC_BITS stages, one quotient bit each) and
// the output register. The whole pipeline holds while the output is stalled and full; bubbles
// pass through. Registers: 0 mode (0 sigmoid, 1 linear), 1 start, 2 target, 3 duration ms,
// 4 steepness (0.001 per ms); write them only while no item is in flight.
module sigmoid_angle_profile_unit #(
  parameter int FRAC_BITS = 23
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [15:0]        time_ms_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] angle_o
);

  localparam int Y_W   = FRAC_BITS + 7;
  localparam int E_W   = FRAC_BITS + 17;
  localparam int D2_NW = FRAC_BITS + 16;
  localparam int D2_DW = FRAC_BITS + 18;
  localparam longint unsigned Y_OFS =
      (64'd43677448 * (64'd1 << FRAC_BITS) + 64'd500000000) / 64'd1000000000;

  // configuration
  sap_pkg::mode_e     mode_q;
  logic signed [15:0] start_q, target_q;
  logic [15:0]        dur_q, steep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= sap_pkg::MODE_SIGMOID;
      start_q  <= '0;
      target_q <= '0;
      dur_q    <= sap_pkg::DUR_RST;
      steep_q  <= sap_pkg::STEEP_RST;
    end else if (cfg_we_i) begin
      unique case (sap_pkg::cfg_reg_e'(cfg_idx_i))
        sap_pkg::REG_MODE:   mode_q   <= sap_pkg::mode_e'(cfg_data_i[0]);
        sap_pkg::REG_START:  start_q  <= cfg_data_i;
        sap_pkg::REG_TARGET: target_q <= cfg_data_i;
        sap_pkg::REG_DUR:    dur_q    <= cfg_data_i;
        sap_pkg::REG_STEEP:  steep_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [16:0] diff_w;
  logic               dneg;
  logic [15:0]        dmag;
  logic signed [15:0] lo_w, hi_w;

  assign diff_w = $signed({target_q[15], target_q}) - $signed({start_q[15], start_q});
  assign dneg   = diff_w[16];
  assign dmag   = dneg ? 16'(-diff_w) : diff_w[15:0];
  assign lo_w   = (!dneg && diff_w != 17'sd0) ? start_q : target_q;
  assign hi_w   = (!dneg && diff_w != 17'sd0) ? target_q : start_q;

  // global advance: move when the output register is empty or being taken
  logic adv;
  logic out_vld_q;
  assign adv     = !out_vld_q || !stall_i;
  assign stall_o = !adv;

  // front
  logic            fr_vld;
  sap_pkg::front_t fr;

  sap_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (valid_i),
    .time_i  (time_ms_i),
    .dur_i   (dur_q),
    .steep_i (steep_q),
    .vld_o   (fr_vld),
    .data_o  (fr)
  );

  // exponent scaling: floor(|n| * 25000 * 2^Q / 34657359) as |n| times a reciprocal rounded
  // up with 42 guard bits, exact for |n| <= 2^16. The divisor shares no factor with
  // 25000 * 2^Q, so the quotient is inexact for every nonzero |n|.
  localparam int RCP_G = 42;
  localparam logic [127:0] RCP_FULL =
      ((128'(sap_pkg::Y_MUL) << (FRAC_BITS + RCP_G)) + 128'(sap_pkg::YDIV_DEN) - 128'd1) /
      128'(sap_pkg::YDIV_DEN);
  localparam logic [71:0] RCP = RCP_FULL[71:0];

  logic           mul_vld_q, mul_nz_q;
  logic [16:0]    mul_side_q;
  logic [40:0]    pp0_q, pp1_q, pp2_q;
  logic [89:0]    rsum;
  logic           yv_q, ynz_q;
  logic [16:0]    yside_q;
  logic [Y_W-1:0] ymag_q;

  assign rsum = 90'(pp0_q) + (90'(pp1_q) << 24) + (90'(pp2_q) << 48);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      yv_q      <= 1'b0;
    end else if (adv) begin
      mul_vld_q <= fr_vld;
      yv_q      <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp0_q      <= fr.mag * RCP[23:0];
      pp1_q      <= fr.mag * RCP[47:24];
      pp2_q      <= fr.mag * RCP[71:48];
      mul_nz_q   <= (fr.mag != '0);
      mul_side_q <= {fr.neg, fr.t};
      ymag_q     <= rsum[RCP_G +: Y_W];
      ynz_q      <= mul_nz_q;
      yside_q    <= mul_side_q;
    end
  end

  // y stage: floor for negative n, then subtract the bias
  logic               v5_q;
  logic [15:0]        t5_q;
  logic signed [Y_W-1:0] y_d, y_q, yq;

  always_comb begin
    yq = $signed(ymag_q);
    if (yside_q[16]) begin
      yq = -(yq + Y_W'(ynz_q));
    end
    y_d = yq - Y_W'(Y_OFS);
  end

  // exponent stage: 2^p * (1 + frac), then pick divider operands
  logic signed [6:0] p_w;
  logic [6:0]        negp;
  logic [FRAC_BITS:0] m_w;
  logic [E_W-1:0]    e_w;
  logic              big_w;
  logic [31:0]       lin_num;
  logic [D2_NW-1:0]  num_d, num6_q;
  logic [D2_DW-1:0]  den_d, den6_q;
  logic              v6_q, big6_q;

  always_comb begin
    p_w   = y_q[Y_W-1:FRAC_BITS];
    negp  = 7'(-p_w);
    m_w   = {1'b1, y_q[FRAC_BITS-1:0]};
    big_w = !p_w[6] && (p_w >= 7'sd17);
    if (!p_w[6]) begin
      e_w = E_W'(m_w) << p_w[4:0];
    end else begin
      e_w = E_W'(m_w) >> negp;
    end
    lin_num = dmag * t5_q;
    if (mode_q == sap_pkg::MODE_LINEAR) begin
      num_d = D2_NW'(lin_num);
      den_d = D2_DW'(dur_q);
    end else begin
      num_d = {dmag, {FRAC_BITS{1'b0}}};
      den_d = (D2_DW'(1) << FRAC_BITS) + D2_DW'(e_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v5_q <= yv_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_q    <= y_d;
      t5_q   <= yside_q[15:0];
      num6_q <= num_d;
      den6_q <= den_d;
      big6_q <= big_w;
    end
  end

  // angle divider
  logic             d2_vld, d2_big;
  logic [D2_NW-1:0] d2_quo;

  sap_div #(.NW(D2_NW), .DW(D2_DW), .SW(1)) u_div_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (v6_q),
    .num_i    (num6_q),
    .den_i    (den6_q),
    .side_i   (big6_q),
    .vld_o    (d2_vld),
    .quo_o    (d2_quo),
    .side_o   (d2_big)
  );

  // output stage
  logic signed [33:0] sq, sum;
  logic signed [15:0] res;

  always_comb begin
    sq  = $signed({2'b00, d2_quo[31:0]});
    if (dneg) begin
      sq = -sq;
    end
    sum = $signed({{18{start_q[15]}}, start_q}) + sq;
    if (mode_q == sap_pkg::MODE_LINEAR) begin
      if (dur_q == 16'd0) begin
        res = target_q;
      end else if (sum < $signed({{18{lo_w[15]}}, lo_w})) begin
        res = lo_w;
      end else if (sum > $signed({{18{hi_w[15]}}, hi_w})) begin
        res = hi_w;
      end else begin
        res = sum[15:0];
      end
    end else begin
      res = d2_big ? start_q : sum[15:0];
    end
  end

  logic signed [15:0] angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      angle_q <= res;
    end
  end

  assign valid_o = out_vld_q;
  assign angle_o = angle_q;

  // the pipeline freezes whole while the output is held
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(d2_vld) && (!d2_vld || $stable(d2_quo)))
    else $error("divider moved while pipeline held");

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2_vld |-> (res >= lo_w) && (res <= hi_w))
    else $error("angle outside start/target range");

  a_big: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2_vld && d2_big && (mode_q == sap_pkg::MODE_SIGMOID) && adv
      |=> angle_q == $past(start_q))
    else $error("large exponent did not give start angle");

endmodule
